[src/arp_cache_table_macros.svh]
// Assertion macros for the ARP cache table.
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// Same-cycle implication, checked on clk, quiet during reset.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet during reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/arpc_pkg.sv]
// Shared types and constants for the ARP cache table.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AGE_W  = 64;
  localparam int SLOT_W = 5;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Start bound for the oldest-entry search
  localparam logic [AGE_W-1:0] AGE_NONE = {AGE_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_rd_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_wr_t;

endpackage

[src/arpc_store.sv]
// Entry storage: key, MAC and age memories plus reset-cleared valid flops.
`timescale 1ns / 1ps
module arpc_store import arpc_pkg::*; #(
  parameter int ENTRIES = 32,
  parameter int IDX_W   = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_rd_t        rd_data,
  output logic             rd_chk,
  output logic [IDX_W-1:0] rd_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_wr_t        wr_data
);

  logic [IP_W-1:0]  mem_ip  [ENTRIES];
  logic [MAC_W-1:0] mem_mac [ENTRIES];
  logic [AGE_W-1:0] mem_age [ENTRIES];
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ip[wr_addr]  <= wr_data.ip;
      mem_mac[wr_addr] <= wr_data.mac;
      mem_age[wr_addr] <= wr_data.age;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.ip    <= mem_ip[rd_addr];
      rd_data.mac   <= mem_mac[rd_addr];
      rd_data.age   <= mem_age[rd_addr];
      rd_data.valid <= valid[rd_addr];
      rd_idx        <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_chk <= 1'b0;
    end else begin
      rd_chk <= rd_en;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

[src/arpc_match.sv]
// Shared compare unit: one entry per cycle, tracks match, free slot and oldest.
`timescale 1ns / 1ps
module arpc_match import arpc_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             clear,
  input  logic [IP_W-1:0]  key,
  input  logic             chk,
  input  logic [IDX_W-1:0] chk_idx,
  input  entry_rd_t        ent,
  output logic             found,
  output logic [IDX_W-1:0] found_idx,
  output logic [MAC_W-1:0] found_mac,
  output logic             free_ok,
  output logic [IDX_W-1:0] free_idx,
  output logic [IDX_W-1:0] victim_idx
);

  logic [AGE_W-1:0] best;

  always_ff @(posedge clk) begin
    if (clear) begin
      found      <= 1'b0;
      free_ok    <= 1'b0;
      best       <= AGE_NONE;
      victim_idx <= '0;
    end else if (chk) begin
      // lowest-index hit wins
      if (!found && ent.valid && (ent.ip == key)) begin
        found     <= 1'b1;
        found_idx <= chk_idx;
        found_mac <= ent.mac;
      end
      if (!free_ok && !ent.valid) begin
        free_ok  <= 1'b1;
        free_idx <= chk_idx;
      end
      // strict compare keeps the lower index on a tie
      if (ent.valid && (ent.age < best)) begin
        best       <= ent.age;
        victim_idx <= chk_idx;
      end
    end
  end

endmodule

[src/arp_cache_table.sv]
// ARP cache table top level: sequencer, age counter and result register.
//
//  channel   signals                      handshake
//  --------  ---------------------------  -----------------------------------
//  command   cmd, ip_addr, mac_in         taken on start && !busy
//  result    hit, mac_out, slot           valid for one cycle while done high
//
// From acceptance to the done strobe an item passes through the scan of the
// entry memories, one read a cycle through a single port, one pipeline slot
// for the registered read and the decide/write state, S_FIN.
// busy drops in the cycle done is shown, so the next item is taken at the
// edge ending it; no new item is taken while busy is high.
// Reset clears the valid bits, the age counter and the sequencer at once;
// no clearing pass. The receiver cannot stall; done is never held off.
`timescale 1ns / 1ps
module arp_cache_table import arpc_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [IP_W-1:0]   ip_addr,
  input  logic [MAC_W-1:0]  mac_in,
  output logic              done,
  output logic              hit,
  output logic [MAC_W-1:0]  mac_out,
  output logic [SLOT_W-1:0] slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [CNT_W-1:0] cnt;

  // latched command
  logic             op;
  logic [IP_W-1:0]  key;
  logic [MAC_W-1:0] mac_hold;

  logic [AGE_W-1:0] age_counter;
  logic [AGE_W-1:0] age_counter_next;

  logic             accept;
  logic             rd_en;
  entry_rd_t        rd_data;
  logic             rd_chk;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [IDX_W-1:0] target;
  entry_wr_t        wr_data;

  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [MAC_W-1:0] found_mac;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;

  logic [IDX_W-1:0]        res_idx;
  logic [IDX_W+SLOT_W-1:0] res_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // one read per scan cycle but the last, which drains the registered read
  assign rd_en = (state == S_SCAN) && (cnt != CNT_W'(ENTRIES));

  assign age_counter_next = age_counter + AGE_W'(1);

  // hit updates in place, else lowest free slot, else oldest entry
  always_comb begin
    priority if (found) begin
      target = found_idx;
    end else if (free_ok) begin
      target = free_idx;
    end else begin
      target = victim_idx;
    end
  end

  assign wr_en        = (state == S_FIN) && (op == CMD_ADD);
  assign wr_data.ip   = key;
  assign wr_data.mac  = mac_hold;
  assign wr_data.age  = age_counter_next;

  // slot carries the low bits of the index, zero-extended for small tables
  assign res_idx = (op == CMD_ADD) ? target : (found ? found_idx : '0);
  assign res_ext = {{SLOT_W{1'b0}}, res_idx};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == CNT_W'(ENTRIES)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      age_counter <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
      if (wr_en) begin
        age_counter <= age_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= cmd;
      key      <= ip_addr;
      mac_hold <= mac_in;
      cnt      <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (state == S_FIN) begin
      hit     <= found;
      mac_out <= ((op == CMD_LOOKUP) && found) ? found_mac : '0;
      slot    <= res_ext[SLOT_W-1:0];
    end
  end

  arpc_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .rd_chk  (rd_chk),
    .rd_idx  (rd_idx),
    .wr_en   (wr_en),
    .wr_addr (target),
    .wr_data (wr_data)
  );

  arpc_match #(
    .IDX_W (IDX_W)
  ) u_match (
    .clk        (clk),
    .clear      (accept),
    .key        (key),
    .chk        (rd_chk),
    .chk_idx    (rd_idx),
    .ent        (rd_data),
    .found      (found),
    .found_idx  (found_idx),
    .found_mac  (found_mac),
    .free_ok    (free_ok),
    .free_idx   (free_idx),
    .victim_idx (victim_idx)
  );

  // checks
  `include "arp_cache_table_macros.svh"

  `ARPC_ASSERT_NEXT(a_fin_strobes, (state == S_FIN), (done && !busy), "result not strobed")
  `ARPC_ASSERT_NOW(a_miss_no_mac, (done && !hit), (mac_out == '0), "miss with nonzero MAC")
  `ARPC_ASSERT_NEXT(a_accept_scans, accept, ((state == S_SCAN) && (cnt == '0)), "scan not begun")
  `ARPC_ASSERT_NOW(a_no_read_write, wr_en, !rd_en, "read and write in one cycle")

endmodule
